// ===== rtl/bb_pkg.sv =====
// Shared constants for the clipped-window RGB box blur.
// No dependencies.
package bb_pkg;

    localparam int DEF_WIDTH_LIMIT  = 1024;
    localparam int DEF_HEIGHT_LIMIT = 1024;
    localparam int DEF_MAX_RADIUS   = 15;

    localparam int RADIUS_DEFAULT = 3;
    localparam int RESET_DIM      = 1024;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

endpackage

// ===== rtl/bb_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module bb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/rgb_box_blur_edge_clipped.sv =====
// Clipped-window RGB888 box blur, top level.
// Depends on bb_pkg and bb_ram.
//
// Pixels enter in raster order and land in a ring of 2*MAX_RADIUS+2 rows held in
// one RAM. When an item is taken and the window of the next pending result is
// complete, the block walks that window through the RAM read port, one pixel per
// cycle, then divides the three channel sums by the clipped pixel count with a
// restoring divider, one quotient bit per cycle. An item with no result passes
// IDLE and CHK only; one with a result also passes SUM, FLUSH, DIV and OUT, its
// time set by the window pixels (up to (2R+1)^2) on the one RAM read port and by
// the sum width in the bit-serial divider. A finished result waits in an output
// register while the next item is taken. Drain items (tuser = 1) flush pending
// results; tlast marks the region end. Radius, width or height writes restart it.
module rgb_box_blur_edge_clipped #(
    parameter int WIDTH_LIMIT  = bb_pkg::DEF_WIDTH_LIMIT,
    parameter int HEIGHT_LIMIT = bb_pkg::DEF_HEIGHT_LIMIT,
    parameter int MAX_RADIUS   = bb_pkg::DEF_MAX_RADIUS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [23:0]                   s_axis_tdata,  // in_red, in_green, in_blue
    input  logic                          s_axis_tuser,  // kind
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [23:0]                   m_axis_tdata,  // out_red, out_green, out_blue
    output logic                          m_axis_tlast,
    input  logic                          i_cfg_we,
    input  logic [bb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bb_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bb_pkg::*;

    localparam int RING  = 2 * MAX_RADIUS + 2;
    localparam int DEPTH = RING * WIDTH_LIMIT;
    localparam int AW    = $clog2(DEPTH);
    localparam int DW    = $clog2(WIDTH_LIMIT + 1);
    localparam int HW    = $clog2(HEIGHT_LIMIT + 1);
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int GW    = $clog2(RING);
    localparam int SPAN  = 2 * MAX_RADIUS + 1;
    localparam int NW    = $clog2(SPAN + 1);
    localparam int CNW   = 2 * NW;
    localparam int SW    = 8 + CNW;
    localparam int QW    = $clog2(SW + 1);
    localparam int RST_RAD = (RADIUS_DEFAULT > MAX_RADIUS) ? MAX_RADIUS : RADIUS_DEFAULT;
    localparam int RST_WID = (RESET_DIM > WIDTH_LIMIT) ? WIDTH_LIMIT : RESET_DIM;
    localparam int RST_HGT = (RESET_DIM > HEIGHT_LIMIT) ? HEIGHT_LIMIT : RESET_DIM;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CHK, ST_SUM, ST_FLUSH, ST_DIV, ST_OUT
    } t_state;

    t_state r_state;

    logic [RW-1:0] r_rad;
    logic [DW-1:0] r_wid;
    logic [HW-1:0] r_hgt;

    logic [HW-1:0] r_in_row, r_out_row;
    logic [DW-1:0] r_in_col, r_out_col;
    logic [GW-1:0] r_in_ring, r_out_ring;

    logic [HW-1:0] r_y, r_y1;
    logic [DW-1:0] r_x, r_x0, r_x1;
    logic [GW-1:0] r_yr;
    logic [CNW-1:0] r_cnt;
    logic          r_rd_v;
    logic [SW-1:0] r_sum [3];
    logic [SW-1:0] r_num [3];
    logic [CNW:0]  r_rem [3];
    logic [QW-1:0] r_bit;

    logic [23:0] r_odata;
    logic        r_olast;
    logic        r_ov;

    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [23:0]   mem_rdata;

    logic [31:0] cfg32;
    logic [RW-1:0] n_rad;
    logic [DW-1:0] n_wid;
    logic [HW-1:0] n_hgt;

    logic [HW:0]   oy_hi, ny;
    logic [DW:0]   ox_hi, nx;
    logic [HW-1:0] y0;
    logic [DW-1:0] x0;
    logic          ready;
    logic [GW:0]   dy, ring0;
    logic [NW-1:0] ny_cnt, nx_cnt;
    logic [CNW:0]  sh_rem [3];
    logic          accept;
    logic          out_free;
    logic          out_load;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_ov || m_axis_tready;
    assign out_load      = !i_cfg_we && (r_state == ST_OUT) && out_free;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

    // effective register values
    always_comb begin
        cfg32 = 32'(i_cfg_data);
        if (cfg32[3:0] == 4'd0) begin
            n_rad = RW'(RADIUS_DEFAULT);
        end else begin
            n_rad = RW'(cfg32[3:0]);
        end
        if (32'(cfg32[3:0]) > MAX_RADIUS) begin
            n_rad = RW'(MAX_RADIUS);
        end else if (cfg32[3:0] != 4'd0 && 32'(RADIUS_DEFAULT) > MAX_RADIUS) begin
            n_rad = RW'(cfg32[3:0]);
        end else if (cfg32[3:0] == 4'd0 && 32'(RADIUS_DEFAULT) > MAX_RADIUS) begin
            n_rad = RW'(MAX_RADIUS);
        end
        if (cfg32 == 32'd0) begin
            n_wid = DW'(1);
            n_hgt = HW'(1);
        end else begin
            n_wid = (cfg32 > 32'(WIDTH_LIMIT))  ? DW'(WIDTH_LIMIT)  : cfg32[DW-1:0];
            n_hgt = (cfg32 > 32'(HEIGHT_LIMIT)) ? HW'(HEIGHT_LIMIT) : cfg32[HW-1:0];
        end
    end

    // window bounds and ready rule
    always_comb begin
        oy_hi = {1'b0, r_out_row} + (HW+1)'(r_rad);
        ox_hi = {1'b0, r_out_col} + (DW+1)'(r_rad);
        ny    = (oy_hi > (HW+1)'(r_hgt - 1'b1)) ? (HW+1)'(r_hgt - 1'b1) : oy_hi;
        nx    = (ox_hi > (DW+1)'(r_wid - 1'b1)) ? (DW+1)'(r_wid - 1'b1) : ox_hi;
        y0    = (r_out_row > HW'(r_rad)) ? r_out_row - HW'(r_rad) : '0;
        x0    = (r_out_col > DW'(r_rad)) ? r_out_col - DW'(r_rad) : '0;
        ready = ((HW+1)'(r_in_row) > ny)
             || (((HW+1)'(r_in_row) == ny) && ((DW+1)'(r_in_col) > nx));
        dy    = (GW+1)'(r_out_row - y0);
        ring0 = ((GW+1)'(r_out_ring) >= dy) ? (GW+1)'(r_out_ring) - dy
                                            : (GW+1)'(r_out_ring) + (GW+1)'(RING) - dy;
        ny_cnt = NW'(ny - (HW+1)'(y0) + 1'b1);
        nx_cnt = NW'(nx - (DW+1)'(x0) + 1'b1);
        for (int c = 0; c < 3; c++) begin
            sh_rem[c] = {r_rem[c][CNW-1:0], r_num[c][SW-1]};
        end
    end

    assign mem_we    = accept && (s_axis_tuser == KIND_PIXEL) && (r_in_row < r_hgt);
    assign mem_waddr = AW'(32'(r_in_ring) * WIDTH_LIMIT + 32'(r_in_col));
    assign mem_raddr = AW'(32'(r_yr) * WIDTH_LIMIT + 32'(r_x));

    bb_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_row_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (s_axis_tdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_rad      <= RW'(RST_RAD);
            r_wid      <= DW'(RST_WID);
            r_hgt      <= HW'(RST_HGT);
            r_in_row   <= '0;
            r_in_col   <= '0;
            r_in_ring  <= '0;
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_out_ring <= '0;
            r_rd_v     <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_ov   <= out_load || (r_ov && !m_axis_tready);
            r_rd_v <= !i_cfg_we && (r_state == ST_SUM);
            if (r_rd_v) begin
                r_sum[0] <= r_sum[0] + SW'(mem_rdata[23:16]);
                r_sum[1] <= r_sum[1] + SW'(mem_rdata[15:8]);
                r_sum[2] <= r_sum[2] + SW'(mem_rdata[7:0]);
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_RADIUS: r_rad <= n_rad;
                    REG_WIDTH:  r_wid <= n_wid;
                    REG_HEIGHT: r_hgt <= n_hgt;
                    default: ;
                endcase
                if (i_cfg_idx == REG_RADIUS || i_cfg_idx == REG_WIDTH
                    || i_cfg_idx == REG_HEIGHT) begin
                    r_in_row   <= '0;
                    r_in_col   <= '0;
                    r_in_ring  <= '0;
                    r_out_row  <= '0;
                    r_out_col  <= '0;
                    r_out_ring <= '0;
                    r_state    <= ST_IDLE;
                end
            end else begin
                unique case (r_state)
                    ST_IDLE: begin
                        if (accept) begin
                            if (mem_we) begin
                                if (r_in_col + 1'b1 >= r_wid) begin
                                    r_in_col  <= '0;
                                    r_in_row  <= r_in_row + 1'b1;
                                    r_in_ring <= (32'(r_in_ring) == RING - 1) ? '0
                                                 : r_in_ring + 1'b1;
                                end else begin
                                    r_in_col <= r_in_col + 1'b1;
                                end
                            end
                            r_state <= ST_CHK;
                        end
                    end
                    ST_CHK: begin
                        if (ready) begin
                            r_y   <= y0;
                            r_y1  <= HW'(ny);
                            r_yr  <= GW'(ring0);
                            r_x   <= x0;
                            r_x0  <= x0;
                            r_x1  <= DW'(nx);
                            r_cnt <= CNW'(ny_cnt) * CNW'(nx_cnt);
                            for (int c = 0; c < 3; c++) begin
                                r_sum[c] <= '0;
                            end
                            r_state <= ST_SUM;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                    ST_SUM: begin
                        if (r_x == r_x1) begin
                            r_x  <= r_x0;
                            r_y  <= r_y + 1'b1;
                            r_yr <= (32'(r_yr) == RING - 1) ? '0 : r_yr + 1'b1;
                            if (r_y == r_y1) begin
                                r_state <= ST_FLUSH;
                            end
                        end else begin
                            r_x <= r_x + 1'b1;
                        end
                    end
                    ST_FLUSH: begin
                        if (!r_rd_v) begin
                            for (int c = 0; c < 3; c++) begin
                                r_num[c] <= r_sum[c];
                                r_rem[c] <= '0;
                            end
                            r_bit   <= '0;
                            r_state <= ST_DIV;
                        end
                    end
                    ST_DIV: begin
                        for (int c = 0; c < 3; c++) begin
                            if (sh_rem[c] >= (CNW+1)'(r_cnt)) begin
                                r_rem[c] <= sh_rem[c] - (CNW+1)'(r_cnt);
                                r_num[c] <= {r_num[c][SW-2:0], 1'b1};
                            end else begin
                                r_rem[c] <= sh_rem[c];
                                r_num[c] <= {r_num[c][SW-2:0], 1'b0};
                            end
                        end
                        r_bit <= r_bit + 1'b1;
                        if (32'(r_bit) == SW - 1) begin
                            r_state <= ST_OUT;
                        end
                    end
                    ST_OUT: begin
                        if (out_free) begin
                            r_odata <= {r_num[0][7:0], r_num[1][7:0], r_num[2][7:0]};
                            r_olast <= (r_out_col + 1'b1 >= r_wid)
                                    && (r_out_row + 1'b1 >= r_hgt);
                            r_state <= ST_IDLE;
                            if (r_out_col + 1'b1 >= r_wid) begin
                                r_out_col  <= '0;
                                r_out_row  <= r_out_row + 1'b1;
                                r_out_ring <= (32'(r_out_ring) == RING - 1) ? '0
                                              : r_out_ring + 1'b1;
                                if (r_out_row + 1'b1 >= r_hgt) begin
                                    r_in_row   <= '0;
                                    r_in_col   <= '0;
                                    r_in_ring  <= '0;
                                    r_out_row  <= '0;
                                    r_out_ring <= '0;
                                end
                            end else begin
                                r_out_col <= r_out_col + 1'b1;
                            end
                        end
                    end
                    default: r_state <= ST_IDLE;
                endcase
            end
        end
    end

endmodule
